FILE: rtl/core/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared widths, payload types and register indexes of the radial gradient
// pixel core.
// ----------------------------------------------------------------------------
package rgp_pkg;

   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int GREY_W  = 8;

   // squared radius, squared diagonal and the scaled dividend
   localparam int R2_W  = 2 * COORD_W + 1;
   localparam int D2_W  = 2 * DIM_W + 1;
   localparam int NUM_W = R2_W + 16;
   localparam int Q_W   = 2 * GREY_W;
   localparam int CMP_W = D2_W + Q_W - 1;

   // 255 * 255, the full-scale quotient
   localparam logic [Q_W-1:0] Q_MAX = 16'd65025;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd256;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd512;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [GREY_W-1:0] grey_level;
      logic              out_of_range;
   } rsp_type;

   // per-stage control that rides along with the data
   typedef struct packed {
      logic valid;
      logic out_of_range;
      logic div_zero;
   } ctl_type;

endpackage

FILE: rtl/core/radial_gradient_pixel_core.sv
// ----------------------------------------------------------------------------
// radial_gradient_pixel_core: grey level of a corner-centred radial gradient
// Item accept to rsp_valid: 3 front stages, 16 divider stages (one quotient
// bit each), 8 square root stages, one output register. One item per cycle
// unless stalled; a stall holds each full stage whose successor holds.
// Synchronous reset empties the pipeline and sets width 256, height 512.
// ----------------------------------------------------------------------------
module radial_gradient_pixel_core #(
   parameter int MAX_DIM = rgp_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rgp_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rgp_pkg::rsp_type              rsp_payload,
   input  logic                          csr_we,
   input  logic [rgp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rgp_pkg::DIM_W-1:0]     csr_wdata
);
   import rgp_pkg::*;

   localparam int unsigned DIM_ALL1  = (1 << DIM_W) - 1;
   localparam int unsigned CLAMP_VAL = (MAX_DIM < DIM_ALL1) ? MAX_DIM : DIM_ALL1;
   localparam logic [DIM_W-1:0] CLAMP_DIM = DIM_W'(CLAMP_VAL);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      priority if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > CLAMP_DIM) begin
         r = CLAMP_DIM;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // dimensions are kept already clamped
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(RESET_WIDTH);
         height_ff <= clamp_dim(RESET_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= clamp_dim(csr_wdata);
            CSR_IMAGE_HEIGHT: height_ff <= clamp_dim(csr_wdata);
         endcase
      end
   end

   // stage 1: range check and squares
   ctl_type            s1_ctl_ff;
   logic [2*COORD_W-1:0] s1_xx_ff, s1_yy_ff;
   logic [2*DIM_W-1:0] s1_ww_ff, s1_hh_ff;
   ctl_type            s1_ctl_in;
   logic [DIM_W-1:0]   wm1, hm1;
   logic               s1_ready;

   // stage 2: sums
   ctl_type          s2_ctl_ff;
   logic [R2_W-1:0]  s2_r2_ff;
   logic [D2_W-1:0]  s2_d2_ff;
   logic             s2_ready;

   // stage 3: scaled dividend
   ctl_type          s3_ctl_ff;
   logic [NUM_W-1:0] s3_num_ff;
   logic [D2_W-1:0]  s3_d2_ff;
   logic             s3_ready;
   logic [NUM_W-1:0] num_in;

   logic             div_in_ready;
   ctl_type          div_ctl;
   logic [Q_W-1:0]   div_q;
   logic             sq_in_ready;
   ctl_type          sq_ctl;
   logic [GREY_W-1:0] sq_root;

   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             out_ready;

   assign s3_ready  = !s3_ctl_ff.valid || div_in_ready;
   assign s2_ready  = !s2_ctl_ff.valid || s3_ready;
   assign s1_ready  = !s1_ctl_ff.valid || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      wm1 = width_ff - DIM_W'(1);
      hm1 = height_ff - DIM_W'(1);
      s1_ctl_in.valid        = req_valid;
      s1_ctl_in.out_of_range = (DIM_W'(req_payload.pixel_x) >= width_ff) ||
                               (DIM_W'(req_payload.pixel_y) >= height_ff);
      s1_ctl_in.div_zero     = (wm1 == '0) && (hm1 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (s1_ready) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (s1_ready) begin
         s1_xx_ff <= (2*COORD_W)'(req_payload.pixel_x) * (2*COORD_W)'(req_payload.pixel_x);
         s1_yy_ff <= (2*COORD_W)'(req_payload.pixel_y) * (2*COORD_W)'(req_payload.pixel_y);
         s1_ww_ff <= (2*DIM_W)'(wm1) * (2*DIM_W)'(wm1);
         s1_hh_ff <= (2*DIM_W)'(hm1) * (2*DIM_W)'(hm1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (s2_ready) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      if (s2_ready) begin
         s2_r2_ff <= R2_W'(s1_xx_ff) + R2_W'(s1_yy_ff);
         s2_d2_ff <= D2_W'(s1_ww_ff) + D2_W'(s1_hh_ff);
      end
   end

   // 65025 * r2 as r2 * (2^16 - 2^9 + 1)
   assign num_in = (NUM_W'(s2_r2_ff) << 16) - (NUM_W'(s2_r2_ff) << 9) + NUM_W'(s2_r2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (s3_ready) begin
         s3_ctl_ff <= s2_ctl_ff;
      end
      if (s3_ready) begin
         s3_num_ff <= num_in;
         s3_d2_ff  <= s2_d2_ff;
      end
   end

   rgp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s3_ctl_ff),
      .in_num    (s3_num_ff),
      .in_d2     (s3_d2_ff),
      .in_ready  (div_in_ready),
      .out_ctl   (div_ctl),
      .out_q     (div_q),
      .out_ready (sq_in_ready)
   );

   rgp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (div_ctl),
      .in_v      (div_q),
      .in_ready  (sq_in_ready),
      .out_ctl   (sq_ctl),
      .out_root  (sq_root),
      .out_ready (out_ready)
   );

   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= sq_ctl.valid;
      end
      if (out_ready) begin
         rsp_ff.grey_level   <= sq_ctl.out_of_range ? '1 : sq_root;
         rsp_ff.out_of_range <= sq_ctl.out_of_range;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_oor_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |-> rsp_payload.grey_level == '1)
      else $error("out of range item not saturated");

   a_dims_clamped: assert property (@(posedge clock) disable iff (reset)
      width_ff != '0 && width_ff <= CLAMP_DIM && height_ff != '0 && height_ff <= CLAMP_DIM)
      else $error("dimension register outside clamp range");

   a_radius_inside: assert property (@(posedge clock) disable iff (reset)
      s2_ctl_ff.valid && !s2_ctl_ff.out_of_range |-> D2_W'(s2_r2_ff) <= s2_d2_ff)
      else $error("in-range radius beyond diagonal");
`endif

endmodule

FILE: rtl/core/rgp_div.sv
// ----------------------------------------------------------------------------
// rgp_div
// Pipelined restoring divider, one quotient bit per stage, a new item every
// cycle unless stalled. Quotient clamped to full scale, zero on a zero divisor.
// ----------------------------------------------------------------------------
module rgp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  rgp_pkg::ctl_type          in_ctl,
   input  logic [rgp_pkg::NUM_W-1:0] in_num,
   input  logic [rgp_pkg::D2_W-1:0]  in_d2,
   output logic                      in_ready,
   output rgp_pkg::ctl_type          out_ctl,
   output logic [rgp_pkg::Q_W-1:0]   out_q,
   input  logic                      out_ready
);
   import rgp_pkg::*;

   ctl_type          st_ctl_ff [Q_W];
   logic [NUM_W-1:0] st_p_ff   [Q_W];
   logic [Q_W-1:0]   st_q_ff   [Q_W];
   logic [D2_W-1:0]  st_d2_ff  [Q_W];

   ctl_type          st_ctl_in [Q_W];
   logic [NUM_W-1:0] st_p_in   [Q_W];
   logic [Q_W-1:0]   st_q_in   [Q_W];
   logic [D2_W-1:0]  st_d2_in  [Q_W];
   logic             st_ready  [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      localparam int SH = Q_W - 1 - j;

      ctl_type          src_ctl;
      logic [NUM_W-1:0] src_p;
      logic [Q_W-1:0]   src_q;
      logic [D2_W-1:0]  src_d2;
      logic [CMP_W-1:0] dsh;
      logic             ge;

      if (j == 0) begin : g_first
         assign src_ctl = in_ctl;
         assign src_p   = in_num;
         assign src_q   = '0;
         assign src_d2  = in_d2;
      end else begin : g_next
         assign src_ctl = st_ctl_ff[j-1];
         assign src_p   = st_p_ff[j-1];
         assign src_q   = st_q_ff[j-1];
         assign src_d2  = st_d2_ff[j-1];
      end

      if (j == Q_W - 1) begin : g_last_rdy
         assign st_ready[j] = !st_ctl_ff[j].valid || out_ready;
      end else begin : g_mid_rdy
         assign st_ready[j] = !st_ctl_ff[j].valid || st_ready[j+1];
      end

      always_comb begin
         dsh = CMP_W'(src_d2) << SH;
         ge  = CMP_W'(src_p) >= dsh;
         st_ctl_in[j] = src_ctl;
         st_d2_in[j]  = src_d2;
         st_q_in[j]   = src_q;
         st_q_in[j][SH] = ge;
         st_p_in[j]   = ge ? NUM_W'(CMP_W'(src_p) - dsh) : src_p;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ctl_ff[j] <= '0;
         end else if (st_ready[j]) begin
            st_ctl_ff[j] <= st_ctl_in[j];
         end
         if (st_ready[j]) begin
            st_p_ff[j]  <= st_p_in[j];
            st_q_ff[j]  <= st_q_in[j];
            st_d2_ff[j] <= st_d2_in[j];
         end
      end
   end

   assign in_ready = st_ready[0];
   assign out_ctl  = st_ctl_ff[Q_W-1];

   always_comb begin
      priority if (st_ctl_ff[Q_W-1].div_zero) begin
         out_q = '0;
      end else if (st_q_ff[Q_W-1] > Q_MAX) begin
         out_q = Q_MAX;
      end else begin
         out_q = st_q_ff[Q_W-1];
      end
   end

`ifndef SYNTH
   // an in-range pixel never lies beyond the diagonal
   a_q_full_scale: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid && !out_ctl.out_of_range && !out_ctl.div_zero
         |-> st_q_ff[Q_W-1] <= Q_MAX)
      else $error("quotient above full scale");
`endif

endmodule

FILE: rtl/core/rgp_sqrt.sv
// ----------------------------------------------------------------------------
// rgp_sqrt
// Pipelined integer square root, one result bit per stage, a new item every
// cycle unless stalled.
// ----------------------------------------------------------------------------
module rgp_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  rgp_pkg::ctl_type           in_ctl,
   input  logic [rgp_pkg::Q_W-1:0]    in_v,
   output logic                       in_ready,
   output rgp_pkg::ctl_type           out_ctl,
   output logic [rgp_pkg::GREY_W-1:0] out_root,
   input  logic                       out_ready
);
   import rgp_pkg::*;

   ctl_type           st_ctl_ff [GREY_W];
   logic [Q_W-1:0]    st_v_ff   [GREY_W];
   logic [GREY_W-1:0] st_r_ff   [GREY_W];

   logic [GREY_W-1:0] st_r_in   [GREY_W];
   logic              st_ready  [GREY_W];

   for (genvar j = 0; j < GREY_W; j++) begin : g_stage
      localparam int BIT = GREY_W - 1 - j;

      ctl_type           src_ctl;
      logic [Q_W-1:0]    src_v;
      logic [GREY_W-1:0] src_r;
      logic [GREY_W-1:0] t;
      logic [Q_W-1:0]    sq;

      if (j == 0) begin : g_first
         assign src_ctl = in_ctl;
         assign src_v   = in_v;
         assign src_r   = '0;
      end else begin : g_next
         assign src_ctl = st_ctl_ff[j-1];
         assign src_v   = st_v_ff[j-1];
         assign src_r   = st_r_ff[j-1];
      end

      if (j == GREY_W - 1) begin : g_last_rdy
         assign st_ready[j] = !st_ctl_ff[j].valid || out_ready;
      end else begin : g_mid_rdy
         assign st_ready[j] = !st_ctl_ff[j].valid || st_ready[j+1];
      end

      always_comb begin
         t = src_r;
         t[BIT] = 1'b1;
         sq = Q_W'(t) * Q_W'(t);
         st_r_in[j] = (sq <= src_v) ? t : src_r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ctl_ff[j] <= '0;
         end else if (st_ready[j]) begin
            st_ctl_ff[j] <= src_ctl;
         end
         if (st_ready[j]) begin
            st_v_ff[j] <= src_v;
            st_r_ff[j] <= st_r_in[j];
         end
      end
   end

   assign in_ready = st_ready[0];
   assign out_ctl  = st_ctl_ff[GREY_W-1];
   assign out_root = st_r_ff[GREY_W-1];

`ifndef SYNTH
   // root is the floor of the exact square root
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |->
         ((Q_W+1)'(out_root) * (Q_W+1)'(out_root) <= (Q_W+1)'(st_v_ff[GREY_W-1])) &&
         (((Q_W+1)'(out_root) + 1'b1) * ((Q_W+1)'(out_root) + 1'b1) >
          (Q_W+1)'(st_v_ff[GREY_W-1])))
      else $error("square root not floored");
`endif

endmodule
